// ===== rtl/pptw_pkg.sv =====
// pptw_pkg: shared types and constants for point_project_to_window
// no dependencies
`default_nettype none
package pptw_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int VP_WIDTH       = 16;
	localparam int VP_UWIDTH      = 15;
	localparam int CFG_IDX_W      = 2;
	localparam int MODE_W         = 2;
	localparam int IDX_W          = 4;

	localparam logic [MODE_W-1:0] MODE_POINT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MODEL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PROJ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_VP_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VP_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VP_W = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VP_H = 2'd3;

	typedef struct packed {
		logic signed [VP_WIDTH-1:0]  vp_x;
		logic signed [VP_WIDTH-1:0]  vp_y;
		logic        [VP_UWIDTH-1:0] vp_w;
		logic        [VP_UWIDTH-1:0] vp_h;
	} vp_cfg_t;
endpackage
`default_nettype wire

// ===== rtl/pptw_mvm.sv =====
// pptw_mvm: 4x4 matrix times vector, pipelined (products, sum, narrow)
// matrix held in registers, loaded by item; uses pptw_pkg
`default_nettype none
module pptw_mvm #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 ld,
	input  wire logic [3:0]           ld_idx,
	input  wire logic signed [DW-1:0] ld_val,
	input  wire logic                 en,
	input  wire logic signed [DW-1:0] v [4],
	output logic signed [DW-1:0]      r [4]
);
	import pptw_pkg::*;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 2;
	logic signed [DW-1:0] m_q [16];
	logic signed [PW-1:0] p_s1 [16];
	logic signed [SW-1:0] s_s2 [4];
	logic signed [SW-1:0] hi;
	logic signed [SW-1:0] lo;

	assign hi = SW'((PW'(1) <<< (DW - 1)) - PW'(1)) <<< FB;
	assign lo = -(SW'(PW'(1) <<< (DW - 1))) <<< FB;

	always_ff @(posedge clk) begin
		if (ld) m_q[ld_idx] <= ld_val;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 16; i++)
				p_s1[i] <= PW'(m_q[i]) * PW'(v[i/4]);
			for (int rr = 0; rr < 4; rr++)
				s_s2[rr] <= SW'(p_s1[rr]) + SW'(p_s1[4+rr]) + SW'(p_s1[8+rr])
					+ SW'(p_s1[12+rr]);
			for (int rr = 0; rr < 4; rr++) begin
				if (s_s2[rr] >= hi + (SW'(1) <<< FB))
					r[rr] <= {1'b0, {(DW-1){1'b1}}};
				else if (s_s2[rr] < lo)
					r[rr] <= {1'b1, {(DW-1){1'b0}}};
				else
					r[rr] <= DW'(s_s2[rr] >>> FB);
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pptw_div.sv =====
// pptw_div: pipelined signed fixed-point divider, one quotient bit a stage
// three numerators share one denominator; uses pptw_pkg
`default_nettype none
module pptw_div #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [DW-1:0] num [3],
	input  wire logic signed [DW-1:0] den,
	output logic signed [DW-1:0]      q [3]
);
	import pptw_pkg::*;
	localparam int NW = DW + FB;
	localparam int ST = NW;
	logic [NW-1:0] n_s [ST+1][3];
	logic [NW-1:0] qq_s [ST+1][3];
	logic [DW:0]   r_s [ST+1][3];
	logic [DW-1:0] d_s [ST+1];
	logic          ng_s [ST+1][3];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0] <= den[DW-1] ? DW'(-den) : DW'(den);
			for (int k = 0; k < 3; k++) begin
				n_s[0][k]  <= {DW'(num[k][DW-1] ? -num[k] : num[k]), {FB{1'b0}}};
				qq_s[0][k] <= '0;
				r_s[0][k]  <= '0;
				ng_s[0][k] <= num[k][DW-1] ^ den[DW-1];
			end
			for (int s = 0; s < ST; s++) begin
				d_s[s+1] <= d_s[s];
				for (int k = 0; k < 3; k++) begin
					logic [DW+1:0] t;
					t = {r_s[s][k], n_s[s][k][NW-1]};
					ng_s[s+1][k] <= ng_s[s][k];
					n_s[s+1][k]  <= n_s[s][k] << 1;
					if (t >= {2'b00, d_s[s]}) begin
						r_s[s+1][k]  <= (DW+1)'(t - {2'b00, d_s[s]});
						qq_s[s+1][k] <= {qq_s[s][k][NW-2:0], 1'b1};
					end else begin
						r_s[s+1][k]  <= (DW+1)'(t);
						qq_s[s+1][k] <= {qq_s[s][k][NW-2:0], 1'b0};
					end
				end
			end
			for (int k = 0; k < 3; k++) begin
				if (ng_s[ST][k]) begin
					if (qq_s[ST][k] > (NW'(1) << (DW - 1)))
						q[k] <= {1'b1, {(DW-1){1'b0}}};
					else
						q[k] <= DW'(-qq_s[ST][k]);
				end else begin
					if (qq_s[ST][k] > (NW'(1) << (DW - 1)) - NW'(1))
						q[k] <= {1'b0, {(DW-1){1'b1}}};
					else
						q[k] <= DW'(qq_s[ST][k]);
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pptw_vp.sv =====
// pptw_vp: viewport map, two stages (scale product, offset and saturate)
// uses pptw_pkg
`default_nettype none
module pptw_vp #(
	parameter int DW = 32,
	parameter int FB = 16
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire pptw_pkg::vp_cfg_t    cfg,
	input  wire logic signed [DW-1:0] ndc [3],
	input  wire logic                 ok,
	output logic signed [DW-1:0]      wx,
	output logic signed [DW-1:0]      wy,
	output logic signed [DW-1:0]      wz
);
	import pptw_pkg::*;
	localparam int EW = DW + 20;
	logic signed [EW-1:0] px_s1, py_s1, sz_s1;
	logic                 ok_s1;
	logic signed [EW-1:0] ax, ay, az;
	logic signed [EW-1:0] sx, sy;

	function automatic logic signed [DW-1:0] sat(input logic signed [EW-1:0] a);
		logic signed [EW-1:0] hi;
		hi = EW'((EW'(1) <<< (DW - 1)) - EW'(1));
		if (a > hi) sat = {1'b0, {(DW-1){1'b1}}};
		else if (a < -hi - EW'(1)) sat = {1'b1, {(DW-1){1'b0}}};
		else sat = DW'(a);
	endfunction

	assign sx = (EW'(1) <<< FB) + EW'(ndc[0]);
	assign sy = (EW'(1) <<< FB) + EW'(ndc[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= sx * EW'(signed'({1'b0, cfg.vp_w}));
			py_s1 <= sy * EW'(signed'({1'b0, cfg.vp_h}));
			sz_s1 <= (EW'(1) <<< FB) + EW'(ndc[2]);
			ok_s1 <= ok;
		end
	end

	assign ax = (EW'(cfg.vp_x) <<< FB) + (px_s1 >>> 1);
	assign ay = (EW'(signed'({1'b0, cfg.vp_h})) <<< FB)
		- ((EW'(cfg.vp_y) <<< FB) + (py_s1 >>> 1));
	assign az = sz_s1 >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx <= ok_s1 ? sat(ax) : '0;
			wy <= ok_s1 ? sat(ay) : '0;
			wz <= ok_s1 ? sat(az) : '0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/point_project_to_window_top.sv =====
// point_project_to_window_top: stream wrapper, two matrix units, divider, viewport
// depends on pptw_pkg, pptw_mvm, pptw_div, pptw_vp
// throughput: one item per cycle; whole pipeline advances when the output is free
// reset: arst_n async clears valid bits and viewport registers; matrices unset
`default_nettype none
module point_project_to_window_top #(
	parameter int DATA_WIDTH = pptw_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = pptw_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [pptw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pptw_pkg::VP_WIDTH-1:0]  cfg_data,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// mode, entry_index, coefficient, point_x, point_y, point_z, zero fill
	input  wire logic [((4*DATA_WIDTH+6+7)/8)*8-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// window_x, window_y, window_z, valid_res, zero fill
	output logic [((3*DATA_WIDTH+1+7)/8)*8-1:0] m_tdata
);
	import pptw_pkg::*;
	localparam int DW = DATA_WIDTH;
	localparam int OW = ((3*DW+1+7)/8)*8;
	localparam int LAT = DW + FRAC_BITS + 10;
	vp_cfg_t cfg_q;
	logic en;
	logic [LAT-1:0] vld_q;
	logic [1:0] ok_q;
	logic [MODE_W-1:0] mode;
	logic [IDX_W-1:0]  idx;
	logic signed [DW-1:0] coef;
	logic signed [DW-1:0] pt [4];
	logic signed [DW-1:0] eye [4];
	logic signed [DW-1:0] clip [4];
	logic signed [DW-1:0] dnum [3];
	logic signed [DW-1:0] ndc [3];
	logic signed [DW-1:0] wx, wy, wz;
	logic acc;
	localparam int DLAT = DW + FRAC_BITS + 2;
	logic [DLAT-1:0] wz_q;
	logic zok;
	logic pld_s1, pld_s2, pld_s3;
	logic [IDX_W-1:0] pidx_s1, pidx_s2, pidx_s3;
	logic signed [DW-1:0] pval_s1, pval_s2, pval_s3;

	assign mode = s_tdata[1:0];
	assign idx  = s_tdata[5:2];
	assign coef = s_tdata[6 +: DW];
	assign pt[0] = s_tdata[6+DW +: DW];
	assign pt[1] = s_tdata[6+2*DW +: DW];
	assign pt[2] = s_tdata[6+3*DW +: DW];
	assign pt[3] = DW'(1) << FRAC_BITS;

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign acc = s_tvalid && s_tready;
	assign m_tvalid = vld_q[LAT-1];
	assign m_tdata = OW'({ok_q[1], wz, wy, wx});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VP_X: cfg_q.vp_x <= cfg_data;
				REG_VP_Y: cfg_q.vp_y <= cfg_data;
				REG_VP_W: cfg_q.vp_w <= cfg_data[VP_UWIDTH-1:0];
				REG_VP_H: cfg_q.vp_h <= cfg_data[VP_UWIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], acc && mode == MODE_POINT};
		end
	end

	// projection load lands where a later point reads the projection matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pld_s1 <= 1'b0;
			pld_s2 <= 1'b0;
			pld_s3 <= 1'b0;
		end else if (en) begin
			pld_s1 <= acc && mode == MODE_PROJ;
			pld_s2 <= pld_s1;
			pld_s3 <= pld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pidx_s1 <= idx;
			pidx_s2 <= pidx_s1;
			pidx_s3 <= pidx_s2;
			pval_s1 <= coef;
			pval_s2 <= pval_s1;
			pval_s3 <= pval_s2;
		end
	end

	// zero-w flag: known after both matrix units (6 stages), carried along
	assign zok = clip[3] != '0;
	always_ff @(posedge clk) begin
		if (en) begin
			wz_q <= {wz_q[DLAT-2:0], zok};
			ok_q <= {ok_q[0], wz_q[DLAT-1]};
		end
	end

	assign dnum[0] = clip[0];
	assign dnum[1] = clip[1];
	assign dnum[2] = clip[2];

	pptw_mvm #(.DW(DW), .FB(FRAC_BITS)) u_model (
		.clk,
		.ld(acc && mode == MODE_MODEL), .ld_idx(idx), .ld_val(coef),
		.en, .v(pt), .r(eye)
	);
	pptw_mvm #(.DW(DW), .FB(FRAC_BITS)) u_proj (
		.clk,
		.ld(pld_s3 && en), .ld_idx(pidx_s3), .ld_val(pval_s3),
		.en, .v(eye), .r(clip)
	);
	pptw_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
		.clk, .en,
		.num(dnum),
		.den(zok ? clip[3] : DW'(1)),
		.q(ndc)
	);
	pptw_vp #(.DW(DW), .FB(FRAC_BITS)) u_vp (
		.clk, .en, .cfg(cfg_q), .ndc, .ok(wz_q[DLAT-1]),
		.wx, .wy, .wz
	);
endmodule
`default_nettype wire
